### design/sfpq_pkg.sv
// Shared constants, codes, state type and index helper for the sorted fraction queue.
// Depends on nothing; imported by sfpq_cmp and the top level.
`default_nettype none

package sfpq_pkg;

    localparam int DEPTH      = 16;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int NUM_W      = 16;
    localparam int DEN_W      = 15;
    localparam int ENT_W      = NUM_W + DEN_W;
    localparam int PROD_W     = NUM_W + DEN_W + 1;
    localparam int ST_W       = 2;
    localparam int OCC_W      = 5;
    localparam int IN_TDATA_W  = ((ENT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = NUM_W + DEN_W + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_DATA_W;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_CMP,
        S_SRD,
        S_SWR,
        S_WNEW,
        S_POPD,
        S_FIN
    } t_state;

    // physical slot of a logical index behind the head of the ring
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, idx};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

`default_nettype wire

### design/sfpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the entry store of the fraction queue.
`default_nettype none

module sfpq_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]                          i_wdata,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]                          o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/sfpq_cmp.sv
// Shared cross-product comparator: registers both products, then compares them.
// Depends on sfpq_pkg.
`default_nettype none

module sfpq_cmp (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic signed [sfpq_pkg::NUM_W-1:0]    i_ent_num,
    input  logic        [sfpq_pkg::DEN_W-1:0]    i_ent_den,
    input  logic signed [sfpq_pkg::NUM_W-1:0]    i_new_num,
    input  logic        [sfpq_pkg::DEN_W-1:0]    i_new_den,
    output logic                                 o_greater
);
    import sfpq_pkg::*;

    logic signed [DEN_W:0]    ent_den_s;
    logic signed [DEN_W:0]    new_den_s;
    logic signed [PROD_W-1:0] r_lhs;
    logic signed [PROD_W-1:0] r_rhs;

    assign ent_den_s = {1'b0, i_ent_den};
    assign new_den_s = {1'b0, i_new_den};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lhs <= i_ent_num * new_den_s;
            r_rhs <= i_new_num * ent_den_s;
        end
    end

    assign o_greater = (r_lhs > r_rhs);

endmodule

`default_nettype wire

### design/sorted_fraction_priority_queue.sv
// Top level of the sorted fraction queue: sequencer, ring pointers and output register.
// Depends on sfpq_pkg, sfpq_ram and sfpq_cmp.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+------------------
//  s_axis   | in  | numerator[15:0], denominator[30:16], pad     | command
//  m_axis   | out | out_numerator, out_denominator, occupancy   | status
//
//  Push on an empty store writes the entry directly; otherwise it reads, multiplies and
//  compares each entry from the front, then moves each entry from the first greater one
//  on one slot back by a read and a write; pop reads the head entry; a full push or
//  empty pop just finishes. The single RAM read port and one comparator make this serial.
//  Reset clears count, head and output valid; the entry RAM needs no clearing pass.
//  A result waits in the output register; a new request is taken meanwhile and stalls
//  only in its own final state until that register frees.
`default_nettype none

module sorted_fraction_priority_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // numerator, denominator, zero pad
    input  logic [sfpq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_numerator, out_denominator, occupancy, zero pad
    output logic [sfpq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status
    output logic [sfpq_pkg::ST_W-1:0]           m_axis_tuser
);
    import sfpq_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_head;
    logic [AW-1:0]            r_k;
    logic [AW-1:0]            r_j;
    logic                     r_cmd;
    logic signed [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]         r_den;
    logic signed [NUM_W-1:0]  r_res_num;
    logic [DEN_W-1:0]         r_res_den;
    logic [ST_W-1:0]          r_res_st;
    logic                     r_o_valid;
    logic signed [NUM_W-1:0]  r_o_num;
    logic [DEN_W-1:0]         r_o_den;
    logic [ST_W-1:0]          r_o_st;
    logic [OCC_W-1:0]         r_o_occ;

    logic                     accept;
    logic                     slot_free;
    logic                     in_cmd;
    logic signed [NUM_W-1:0]  in_num;
    logic [DEN_W-1:0]         in_den;
    logic                     is_full;
    logic                     is_empty;
    logic                     scan_last;
    logic                     shift_last;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [ENT_W-1:0]         ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [ENT_W-1:0]         ram_rdata;
    logic signed [NUM_W-1:0]  rd_num;
    logic [DEN_W-1:0]         rd_den;
    logic                     cmp_load;
    logic                     cmp_greater;

    assign in_cmd     = s_axis_tuser[0];
    assign in_num     = s_axis_tdata[NUM_W-1:0];
    assign in_den     = s_axis_tdata[ENT_W-1:NUM_W];
    assign accept     = s_axis_tvalid & s_axis_tready;
    assign slot_free  = ~r_o_valid | m_axis_tready;
    assign is_full    = (r_count == CW'(DEPTH));
    assign is_empty   = (r_count == '0);
    assign scan_last  = ((CW'(r_k) + CW'(1)) == r_count);
    assign shift_last = ((r_j - AW'(1)) == r_k);
    assign rd_num     = ram_rdata[NUM_W-1:0];
    assign rd_den     = ram_rdata[ENT_W-1:NUM_W];

    sfpq_ram #(
        .P_WIDTH (ENT_W),
        .P_DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sfpq_cmp u_cmp (
        .i_clk     (i_clk),
        .i_load    (cmp_load),
        .i_ent_num (rd_num),
        .i_ent_den (rd_den),
        .i_new_num (r_num),
        .i_new_den (r_den),
        .o_greater (cmp_greater)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_PUSH) begin
                        if (is_full) begin
                            n_state = S_FIN;
                        end else if (is_empty) begin
                            n_state = S_WNEW;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        n_state = is_empty ? S_FIN : S_RD;
                    end
                end
            end
            S_RD:   n_state = (r_cmd == CMD_POP) ? S_POPD : S_MUL;
            S_MUL:  n_state = S_CMP;
            S_CMP: begin
                if (cmp_greater) begin
                    n_state = S_SRD;
                end else begin
                    n_state = scan_last ? S_WNEW : S_RD;
                end
            end
            S_SRD:  n_state = S_SWR;
            S_SWR:  n_state = shift_last ? S_WNEW : S_SRD;
            S_WNEW: n_state = S_FIN;
            S_POPD: n_state = S_FIN;
            S_FIN:  n_state = slot_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = wrap_add(r_head, r_k);
        ram_wdata     = {r_den, r_num};
        ram_raddr     = r_head;
        cmp_load      = 1'b0;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_RD:   ram_raddr = wrap_add(r_head, r_k);
            S_MUL:  cmp_load = 1'b1;
            S_SRD:  ram_raddr = wrap_add(r_head, r_j - AW'(1));
            S_SWR: begin
                // move the entry one slot back
                ram_we    = 1'b1;
                ram_waddr = wrap_add(r_head, r_j);
                ram_wdata = ram_rdata;
            end
            S_WNEW: ram_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_head    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && slot_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_WNEW: r_count <= r_count + CW'(1);
                S_POPD: begin
                    r_head  <= wrap_add(r_head, AW'(1));
                    r_count <= r_count - CW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cmd     <= in_cmd;
                    r_num     <= in_num;
                    r_den     <= in_den;
                    r_k       <= '0;
                    r_j       <= r_count[AW-1:0];
                    r_res_num <= '0;
                    r_res_den <= '0;
                    if (in_cmd == CMD_PUSH) begin
                        r_res_st <= is_full ? ST_FULL : ST_OK;
                    end else begin
                        r_res_st <= is_empty ? ST_EMPTY : ST_OK;
                    end
                end
            end
            S_CMP: begin
                if (!cmp_greater) begin
                    r_k <= r_k + AW'(1);
                end
            end
            S_SWR: r_j <= r_j - AW'(1);
            S_POPD: begin
                r_res_num <= rd_num;
                r_res_den <= rd_den;
            end
            S_FIN: begin
                if (slot_free) begin
                    r_o_num <= r_res_num;
                    r_o_den <= r_res_den;
                    r_o_st  <= r_res_st;
                    r_o_occ <= OCC_W'(r_count);
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_o_occ, r_o_den, r_o_num};
    assign m_axis_tuser  = r_o_st;

endmodule

`default_nettype wire
